[design/utn_pkg.sv]
// Shared types, constants and decode functions for the UTF-8 text normalizer.
`timescale 1ns / 1ps

package utn_pkg;

  // Register decode: one 32-bit register per word, selected by paddr[2].
  localparam int PADDR_W = 3;
  localparam logic REG_LOWERCASE = 1'b0;
  localparam logic REG_CAMEL     = 1'b1;

  // Queue between the classifier and the emitter.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Longest burst delivered for one request.
  localparam int MAX_RESULTS = 7;

  // Word boundary marker, U+2581 in UTF-8.
  localparam logic [7:0] MARK_B0 = 8'hE2;
  localparam logic [7:0] MARK_B1 = 8'h96;
  localparam logic [7:0] MARK_B2 = 8'h81;

  typedef struct packed {
    logic lowercase;
    logic camel;
  } cfg_t;

  typedef struct packed {
    logic space;
    logic upper;
    logic lower;
    logic ascii;
  } cls_t;

  typedef struct packed {
    logic [1:0] off;
    logic [2:0] len;
    cls_t       cls;
  } char_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    char_t [2:0]     chars;
    logic [1:0]      nchar;
    logic            last;
  } entry_t;

  function automatic logic [2:0] width_of_lead(input logic [7:0] b);
    logic [2:0] w;
    if ((b & 8'hE0) == 8'hC0) begin
      w = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      w = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      w = 3'd4;
    end else begin
      w = 3'd1;
    end
    return w;
  endfunction

  function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  function automatic cls_t classify_cp(input logic [20:0] cp);
    cls_t c;
    c.ascii = (cp <= 21'd127);
    if (c.ascii) begin
      c.space = (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D);
    end else begin
      c.space = (cp == 21'h00A0) || (cp == 21'h1680) || (cp == 21'h2007) ||
                (cp == 21'h202F) || (cp == 21'h3000);
    end
    c.upper = (cp >= 21'h41) && (cp <= 21'h5A);
    c.lower = (cp >= 21'h61) && (cp <= 21'h7A);
    return c;
  endfunction

endpackage

[design/utf8_text_normalizer.sv]
// Top level of the UTF-8 whitespace normalizer: configuration registers and the two halves.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake                 Payload
//  input    in         in_valid / in_stall       in_byte, in_last
//  output   out        out_valid / out_stall     out_byte, byte_valid, run_last, text_end
//  config   in/out     APB psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// The front end takes one text byte per cycle whenever the four-entry queue has room.
// A request that completes a character (or ends the text) enters the queue in the same cycle.
// The back end turns one queue entry into a burst of up to seven bytes and
// then delivers one byte per cycle while out_stall is low, loading the next entry as the last byte goes out.
// Reset is synchronous and active high; it clears the gathering state and the prev_* flags and sets need_boundary.
// An output stall only holds the burst register; the front keeps accepting until the queue fills.

module utf8_text_normalizer import utn_pkg::*; (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               text_end,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t   cfg;
  logic   accept;
  logic   push;
  entry_t front_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  // Configuration: bit 0 of each word is the enable; paddr[2] selects the word.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LOWERCASE: cfg.lowercase <= pwdata[0];
        REG_CAMEL:     cfg.camel     <= pwdata[0];
        default:       cfg           <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOWERCASE: prdata = {31'd0, cfg.lowercase};
      REG_CAMEL:     prdata = {31'd0, cfg.camel};
      default:       prdata = 32'd0;
    endcase
  end

  // The input side stalls only when the queue between the two halves is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  utn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .entry   (front_entry)
  );

  utn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (front_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .dout      (q_entry)
  );

  utn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule

[design/utn_front.sv]
// Front end: gathers the bytes of one character and splits them into classified characters.
`timescale 1ns / 1ps

module utn_front import utn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output entry_t     entry
);

  logic [2:0][7:0] pending_bytes;
  logic [1:0]      pending_count;
  logic [2:0]      char_width;

  logic [2:0]      cw;
  logic [2:0]      n;
  logic            complete;
  logic            flush;
  logic [3:0][7:0] buf_b;
  logic [2:0]      w1;
  logic [2:0]      len1;

  always_comb begin
    cw = (pending_count == 2'd0) ? width_of_lead(in_byte) : char_width;
    n  = {1'b0, pending_count} + 3'd1;
    complete = (n >= cw) || in_last;
    flush    = (n < cw);

    for (int k = 0; k < 3; k++) begin
      if (k < pending_count) begin
        buf_b[k] = pending_bytes[k];
      end else if (k == pending_count) begin
        buf_b[k] = in_byte;
      end else begin
        buf_b[k] = 8'h00;
      end
    end
    buf_b[3] = (pending_count == 2'd3) ? in_byte : 8'h00;

    // After an unfinished lead stands alone, the rest is split again from the second byte.
    w1 = width_of_lead(buf_b[1]);
    len1 = (3'd1 + w1 > n) ? 3'd1 : w1;

    entry.bytes = buf_b;
    entry.last  = in_last;

    entry.chars[0].off = 2'd0;
    entry.chars[0].len = flush ? 3'd1 : n;
    entry.chars[0].cls = classify_cp(decode_cp(buf_b[0], buf_b[1], buf_b[2], buf_b[3],
                                               entry.chars[0].len));
    entry.chars[1].off = 2'd1;
    entry.chars[1].len = len1;
    entry.chars[1].cls = classify_cp(decode_cp(buf_b[1], buf_b[2], 8'h00, 8'h00, len1));
    entry.chars[2].off = 2'd2;
    entry.chars[2].len = 3'd1;
    entry.chars[2].cls = classify_cp(decode_cp(buf_b[2], 8'h00, 8'h00, 8'h00, 3'd1));

    if (!flush || n == 3'd1) begin
      entry.nchar = 2'd1;
    end else if (3'd1 + len1 < n) begin
      entry.nchar = 2'd3;
    end else begin
      entry.nchar = 2'd2;
    end

    push = accept && complete;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      char_width    <= 3'd0;
    end else if (accept) begin
      if (complete) begin
        pending_count <= 2'd0;
        char_width    <= 3'd0;
      end else begin
        pending_count <= n[1:0];
        char_width    <= cw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      pending_bytes[pending_count] <= in_byte;
    end
  end

endmodule

[design/utn_queue.sv]
// Short queue of classified requests between the front end and the emitter.
`timescale 1ns / 1ps

module utn_queue import utn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t dout
);

  entry_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

[design/utn_back.sv]
// Back end: applies boundary, camel, lowercase rules; one byte per cycle unless stalled.
`timescale 1ns / 1ps

module utn_back import utn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       text_end
);

  logic need_boundary;
  logic prev_nonspace;
  logic prev_was_lower;

  logic [MAX_RESULTS-1:0][7:0] burst;
  logic [2:0]                  rem;
  logic                        burst_bv;
  logic                        burst_last;

  logic        need_boundary_next;
  logic        prev_nonspace_next;
  logic        prev_was_lower_next;
  logic [71:0] acc;
  logic [3:0]  cnt;
  logic [55:0] seg;
  logic [3:0]  seg_len;
  logic [31:0] body;
  logic [7:0]  first_b;
  logic        out_take;
  logic        can_load;
  logic        empty_end;
  logic [2:0]  load_count;

  always_comb begin
    need_boundary_next  = need_boundary;
    prev_nonspace_next  = prev_nonspace;
    prev_was_lower_next = prev_was_lower;
    acc     = '0;
    cnt     = '0;
    seg     = '0;
    seg_len = '0;
    body    = '0;
    first_b = '0;

    for (int c = 0; c < 3; c++) begin
      seg     = '0;
      seg_len = '0;
      if (c < q_entry.nchar) begin
        if (q_entry.chars[c].cls.space) begin
          need_boundary_next = 1'b1;
          prev_nonspace_next = 1'b0;
        end else begin
          if (cfg.camel && prev_nonspace_next && prev_was_lower_next &&
              q_entry.chars[c].cls.upper) begin
            need_boundary_next = 1'b1;
          end
          body = 32'(q_entry.bytes >> {q_entry.chars[c].off, 3'b000});
          first_b = body[7:0];
          if (cfg.lowercase && q_entry.chars[c].cls.ascii) begin
            if (first_b >= 8'h41 && first_b <= 8'h5A) begin
              first_b = first_b + 8'h20;
            end
            body    = {24'd0, first_b};
            seg_len = 4'd1;
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (k >= q_entry.chars[c].len) begin
                body[8*k +: 8] = 8'h00;
              end
            end
            seg_len = {1'b0, q_entry.chars[c].len};
          end
          if (need_boundary_next) begin
            seg     = {body, MARK_B2, MARK_B1, MARK_B0};
            seg_len = seg_len + 4'd3;
          end else begin
            seg = 56'(body);
          end
          need_boundary_next  = 1'b0;
          prev_was_lower_next = q_entry.chars[c].cls.lower;
          prev_nonspace_next  = 1'b1;
        end
        acc = acc | (72'(seg) << {cnt, 3'b000});
        cnt = cnt + seg_len;
      end
    end

    if (q_entry.last) begin
      need_boundary_next  = 1'b1;
      prev_nonspace_next  = 1'b0;
      prev_was_lower_next = 1'b0;
    end

    empty_end = q_entry.last && (cnt == 4'd0);
    if (cnt > 4'(MAX_RESULTS)) begin
      load_count = 3'(MAX_RESULTS);
    end else begin
      load_count = cnt[2:0];
    end

    out_take = (rem != 3'd0) && !out_stall;
    can_load = (rem == 3'd0) || (out_take && rem == 3'd1);
    q_pop    = q_valid && can_load;
  end

  assign out_valid  = (rem != 3'd0);
  assign out_byte   = burst[0];
  assign byte_valid = burst_bv;
  assign run_last   = (rem == 3'd1);
  assign text_end   = burst_last && (rem == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      need_boundary  <= 1'b1;
      prev_nonspace  <= 1'b0;
      prev_was_lower <= 1'b0;
      rem            <= 3'd0;
    end else begin
      if (q_pop) begin
        need_boundary  <= need_boundary_next;
        prev_nonspace  <= prev_nonspace_next;
        prev_was_lower <= prev_was_lower_next;
        rem            <= empty_end ? 3'd1 : load_count;
      end else if (out_take) begin
        rem <= rem - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      burst      <= empty_end ? '0 : acc[55:0];
      burst_bv   <= !empty_end;
      burst_last <= q_entry.last;
    end else if (out_take) begin
      burst <= burst >> 8;
    end
  end

endmodule

[tb/tb_utf8_text_normalizer.sv]
// Self-checking testbench for the UTF-8 whitespace normalizer with random idling on both sides.
`timescale 1ns / 1ps

module tb_utf8_text_normalizer;
  import utn_pkg::*;

  // Register addresses: one 32-bit word per register.
  localparam logic [PADDR_W-1:0] ADDR_LOWER = {REG_LOWERCASE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_CAMEL = {REG_CAMEL, 2'b00};

  // Word boundary marker (U+2581) as it appears in the output stream.
  localparam logic [7:0] MARK_0 = 8'hE2;
  localparam logic [7:0] MARK_1 = 8'h96;
  localparam logic [7:0] MARK_2 = 8'h81;

  // Code points outside ASCII that count as whitespace.
  localparam logic [20:0] CP_NBSP    = 21'h00A0;
  localparam logic [20:0] CP_OGHAM   = 21'h1680;
  localparam logic [20:0] CP_FIGURE  = 21'h2007;
  localparam logic [20:0] CP_NNBSP   = 21'h202F;
  localparam logic [20:0] CP_IDEO_SP = 21'h3000;

  localparam int BURST_MAX   = 7;
  localparam int SETTLE      = 16;      // cycles to let the back end go quiet
  localparam int LONG_HOLD   = 60;      // receiver hold-off that fills the block
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } norm_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte    = 8'h00;
  logic              in_last    = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [7:0]        out_byte;
  logic              byte_valid;
  logic              run_last;
  logic              text_end;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata     = '0;
  logic [31:0]       prdata;
  logic              pready;

  utf8_text_normalizer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  // Requests waiting to be driven, and normalized bytes waiting to come out.
  text_req_t  pending_reqs[$];
  norm_byte_t expected_bytes[$];

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_texts    = 0;
  int err_count  = 0;
  int cycles     = 0;

  // Flow control shared between the stimulus and the two idling processes.
  bit req_taken     = 1'b0;
  bit calm          = 1'b0;
  bit long_hold_req = 1'b0;
  int hold_left     = 0;
  int send_gap      = 0;
  int stall_gap     = 0;

  // Predictor copy of the configuration and of the normalizer state.
  logic       lower_on     = 1'b0;
  logic       camel_on     = 1'b0;
  logic [7:0] held [3];
  int         held_n       = 0;
  int         cur_width    = 0;
  logic       boundary_due = 1'b1;
  logic       after_text   = 1'b0;
  logic       last_lower   = 1'b0;

  // Bytes produced by the request being predicted; anything past seven is dropped.
  logic [7:0] out_burst [BURST_MAX];
  int         burst_n;

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sequence length announced by a lead byte; anything else stands alone.
  function automatic int lead_width(input logic [7:0] b);
    casez (b)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic bit is_blank(input logic [20:0] cp);
    if (cp <= 21'd127) begin
      return (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D);
    end
    return (cp == CP_NBSP) || (cp == CP_OGHAM) || (cp == CP_FIGURE) ||
           (cp == CP_NNBSP) || (cp == CP_IDEO_SP);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    if (burst_n < BURST_MAX) begin
      out_burst[burst_n] = b;
      burst_n++;
    end
  endfunction

  // One decoded character: whitespace only sets a boundary, everything else is
  // emitted, with the marker first when a boundary is due.
  function automatic void take_char(input logic [20:0] cp, input logic [3:0][7:0] chars,
                                    input int at, input int len);
    logic [7:0] b;
    int         k;
    if (is_blank(cp)) begin
      boundary_due = 1'b1;
      after_text   = 1'b0;
      return;
    end
    if (camel_on && after_text && last_lower && cp >= 21'h41 && cp <= 21'h5A) begin
      boundary_due = 1'b1;
    end
    if (boundary_due) begin
      put_byte(MARK_0);
      put_byte(MARK_1);
      put_byte(MARK_2);
      boundary_due = 1'b0;
    end
    if (lower_on && cp <= 21'd127) begin
      // Only the first byte survives, even for an overlong form.
      b = chars[at];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      put_byte(b);
    end else begin
      for (k = 0; k < len; k++) begin
        put_byte(chars[at + k]);
      end
    end
    last_lower = (cp >= 21'h61 && cp <= 21'h7A);
    after_text = 1'b1;
  endfunction

  // Walk n gathered bytes; a lead without enough followers is taken on its own.
  function automatic void split_chars(input logic [3:0][7:0] chars, input int n);
    int          i;
    int          w;
    logic [7:0]  lead;
    logic [20:0] cp;
    i = 0;
    while (i < n) begin
      lead = chars[i];
      w    = lead_width(lead);
      cp   = {13'd0, lead};
      if (i + w > n) begin
        w = 1;
      end
      case (w)
        2: cp = {10'd0, lead[4:0], chars[i+1][5:0]};
        3: cp = {5'd0, lead[3:0], chars[i+1][5:0], chars[i+2][5:0]};
        4: cp = {lead[2:0], chars[i+1][5:0], chars[i+2][5:0], chars[i+3][5:0]};
        default: ;
      endcase
      take_char(cp, chars, i, w);
      i += w;
    end
  endfunction

  // Works out the normalized bytes caused by one accepted request.
  function automatic void predict_request(input logic [7:0] b, input logic last);
    logic [3:0][7:0] chars;
    norm_byte_t      nb;
    int              n;
    int              k;
    chars   = '0;
    burst_n = 0;
    if (held_n == 0) begin
      cur_width = lead_width(b);
    end
    n = held_n;
    for (k = 0; k < n; k++) begin
      chars[k] = held[k];
    end
    chars[n] = b;
    n++;
    if (n >= cur_width || last) begin
      split_chars(chars, n);
      held_n    = 0;
      cur_width = 0;
    end else begin
      held[n-1] = b;
      held_n    = n;
    end

    if (last && burst_n == 0) begin
      // Text ended with nothing to show: a lone end marker.
      nb = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, text_end: 1'b1};
      expected_bytes.insert(expected_bytes.size(), nb);
    end else begin
      for (k = 0; k < burst_n; k++) begin
        nb.out_byte   = out_burst[k];
        nb.byte_valid = 1'b1;
        nb.run_last   = (k == burst_n - 1);
        nb.text_end   = last && (k == burst_n - 1);
        expected_bytes.insert(expected_bytes.size(), nb);
      end
    end

    if (last) begin
      held_n       = 0;
      cur_width    = 0;
      boundary_due = 1'b1;
      after_text   = 1'b0;
      last_lower   = 1'b0;
      n_texts++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: everything lands in pending_reqs in zero time.
  // ---------------------------------------------------------------------------

  function automatic void push_req(input logic [7:0] b, input logic last);
    text_req_t t;
    t.data = b;
    t.last = last;
    pending_reqs.insert(pending_reqs.size(), t);
    n_pushed++;
  endfunction

  // Pushes the low n bytes of a packed string, most significant first.
  function automatic void push_text(input logic [127:0] bytes, input int n, input logic ends);
    int k;
    for (k = 0; k < n; k++) begin
      push_req(bytes[8*(n-1-k) +: 8], ends && (k == n - 1));
    end
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Marks the newest queued request as the end of its text.
  function automatic void close_text();
    text_req_t t;
    t = pending_reqs.pop_back();
    t.last = 1'b1;
    pending_reqs.insert(pending_reqs.size(), t);
  endfunction

  // Mostly well-formed characters, with some noise and truncated sequences.
  function automatic void add_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      push_req(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
    end else if (pick < 43) begin
      push_req(8'h41 + 8'($urandom_range(0, 25)), 1'b0);
    end else if (pick < 53) begin
      push_req($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b0);
    end else if (pick < 60) begin
      case ($urandom_range(0, 4))
        0:       push_text(16'hC2A0, 2, 1'b0);
        1:       push_text(24'hE19A80, 3, 1'b0);
        2:       push_text(24'hE28087, 3, 1'b0);
        3:       push_text(24'hE280AF, 3, 1'b0);
        default: push_text(24'hE38080, 3, 1'b0);
      endcase
    end else if (pick < 70) begin
      push_req(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
      push_req(cont_byte(), 1'b0);
    end else if (pick < 78) begin
      push_req(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
      push_req(cont_byte(), 1'b0);
      push_req(cont_byte(), 1'b0);
    end else if (pick < 83) begin
      push_req(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
      repeat (3) push_req(cont_byte(), 1'b0);
    end else if (pick < 89) begin
      push_req(8'($urandom_range(0, 127)), 1'b0);
    end else if (pick < 95) begin
      push_req(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // A lead byte short of its followers; the next character gets swallowed.
      push_req(8'hE0 | 8'($urandom_range(0, 23)), 1'b0);
      repeat ($urandom_range(0, 1)) push_req(cont_byte(), 1'b0);
    end
  endfunction

  function automatic void add_text(input int len);
    int pick;
    repeat (len) add_char();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // Text stops in the middle of a character.
      if ($urandom_range(0, 1)) begin
        push_req(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        repeat ($urandom_range(0, 1)) push_req(cont_byte(), 1'b0);
      end else begin
        push_req(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        repeat ($urandom_range(0, 2)) push_req(cont_byte(), 1'b0);
      end
      close_text();
    end else if (pick < 30) begin
      push_req(8'h20, 1'b1);
    end else begin
      close_text();
    end
  endfunction

  function automatic void add_random_texts(input int count);
    int target;
    target = n_pushed + count;
    while (n_pushed < target) begin
      add_text($urandom_range(1, 12));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: inputs change on the falling edge, acceptance is seen on the rising edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_request(in_byte, in_last);
      n_accepted++;
      req_taken = 1'b1;
    end
  end

  // A request stays on the port until taken. Between requests the sender may
  // take a random break, except while the receiver is in its long hold-off,
  // when it keeps offering so the block fills up.
  always @(negedge clk) begin
    text_req_t nxt;
    if (!rst && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && hold_left == 0 && pending_reqs.size() != 0 &&
                   $urandom_range(0, 99) < 15) begin
        send_gap = $urandom_range(1, 13) - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nxt.data;
        in_last  <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 12) begin
      stall_gap = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every delivered byte is matched against the oldest prediction.
  always @(posedge clk) begin
    norm_byte_t got;
    norm_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_byte: out_byte, byte_valid: byte_valid, run_last: run_last,
              text_end: text_end};
      n_checked++;
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected output byte %02h valid %0d run_last %0d text_end %0d",
                             got.out_byte, got.byte_valid, got.run_last, got.text_end));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"output mismatch: expected byte %02h valid %0d run_last %0d ",
                                "text_end %0d, got byte %02h valid %0d run_last %0d text_end %0d"},
                               want.out_byte, want.byte_valid, want.run_last, want.text_end,
                               got.out_byte, got.byte_valid, got.run_last, got.text_end));
        end
      end
    end
  end

  // Watchdog: the whole run should finish far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still expected",
               cycles, expected_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access and phase control
  // ---------------------------------------------------------------------------

  // Writes one register, then reads it back over the same port.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LOWER) begin
      lower_on = value;
    end else begin
      camel_on = value;
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== value) begin
      flag_error($sformatf("register at %0h reads %0d, expected %0d", addr, prdata[0], value));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic lower, input logic camel);
    write_reg(ADDR_LOWER, lower);
    write_reg(ADDR_CAMEL, camel);
  endtask

  // Sender pauses here until every predicted byte has come out; a partial
  // character produces nothing, so the back end is then given time to go quiet.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || n_accepted != n_pushed || expected_bytes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings. Directed text: space, letters, a no-break space, an
    // ideographic space, a four-byte character, an invalid lead byte and a
    // text that stops inside a three-byte sequence; then a text that is only
    // a tab, which gives the empty end marker.
    push_text({8'h20, 8'h41, 8'h7A, 8'hC2, 8'hA0, 8'hE3, 8'h80, 8'h80}, 8, 1'b0);
    push_text({8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hE2, 8'h82}, 7, 1'b1);
    push_text(8'h09, 1, 1'b1);
    // The receiver holds off for a long stretch while random texts keep coming.
    long_hold_req = 1'b1;
    add_random_texts(20);
    wait_idle();

    // Both options on. An unfinished four-byte lead followed by "aB" at text
    // end overflows the seven-byte burst; then a camel split, an overlong
    // space and an overlong 'A' that is emitted as its lead byte only.
    set_mode(1'b1, 1'b1);
    push_text({8'hF0, 8'h61, 8'h42}, 3, 1'b1);
    push_text({8'h7A, 8'h42, 8'hC0, 8'hA0, 8'hC1, 8'h81}, 6, 1'b1);
    add_random_texts(20);
    wait_idle();

    set_mode(1'b1, 1'b0);
    add_random_texts(20);
    wait_idle();

    // Last part runs with no idling on either side.
    set_mode(1'b0, 1'b1);
    calm = 1'b1;
    add_random_texts(20);
    wait_idle();

    $display("Ran %0d requests in %0d texts, checked %0d output bytes,", n_accepted, n_texts,
             n_checked);
    $display("under all four combinations of lowercasing and camel splitting.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
